@@ src/efas_pkg.sv @@
// ----------------------------------------------------------------------------
// efas_pkg
// Shared constants, types and helpers of the earliest-finish selector.
// ----------------------------------------------------------------------------
package efas_pkg;

  localparam int TYPE_COUNT      = 4;
  localparam int MAX_INSTANCES   = 4;
  localparam int JOB_KINDS       = 8;
  localparam int RUN_TIME_FIELDS = 4;

  localparam int TYPE_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int IDX_W  = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int CNT_W  = $clog2(MAX_INSTANCES + 1);

  localparam int TIME_W = 48;
  localparam int RUN_W  = 32;
  localparam int FIN_W  = 33;

  localparam int IN_TDATA_W  = 216;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // request commands
  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_BUSY   = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_CAP  = 2'd1;
  localparam logic [1:0] ST_NO_TASK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAP_MAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS  = 1'd1;

  typedef struct packed {
    logic              en;
    logic              busy;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] start;
    logic [RUN_W-1:0]  expected;
  } mark_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [FIN_W-1:0] fin;
  } lane_res_t;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] ptype;
    logic [IDX_W-1:0]  idx;
    logic [FIN_W-1:0]  fin;
  } pick_t;

  // instance count of type t, clipped to the table depth
  function automatic logic [CNT_W-1:0] count_of(input logic [15:0] counts, input int t);
    logic [3:0] c;
    c = 4'd0;
    if (t < 4) begin
      c = counts[4*t +: 4];
    end
    if (int'(c) > MAX_INSTANCES) begin
      return CNT_W'(MAX_INSTANCES);
    end
    return CNT_W'(c);
  endfunction

  function automatic logic capable(input logic [31:0] cap_map, input logic [2:0] job,
                                   input int t);
    logic [4:0] bit_sel;
    bit_sel = {job, 2'(t)};
    if (t >= RUN_TIME_FIELDS || int'(job) >= JOB_KINDS) begin
      return 1'b0;
    end
    return cap_map[bit_sel];
  endfunction

endpackage

@@ src/efas_lane.sv @@
// ----------------------------------------------------------------------------
// efas_lane
// Instance table of one accelerator type and a three-stage scan that finds
// the instance with the earliest projected finish.
// ----------------------------------------------------------------------------
module efas_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  efas_pkg::mark_t                 mark,
  input  logic                            start,
  input  logic                            capable,
  input  logic [efas_pkg::CNT_W-1:0]      count,
  input  logic [efas_pkg::RUN_W-1:0]      run,
  input  logic [efas_pkg::TIME_W-1:0]     now,
  output efas_pkg::lane_res_t             res,
  output logic                            done
);
  import efas_pkg::*;

  logic [MAX_INSTANCES-1:0] busy_r;
  logic [TIME_W-1:0]        st_mem [MAX_INSTANCES];
  logic [RUN_W-1:0]         ex_mem [MAX_INSTANCES];

  logic             active_r;
  logic [CNT_W-1:0] i_r, cnt_r, i_nxt;

  logic              va_r, busya_r;
  logic [TIME_W-1:0] ela_r;
  logic [RUN_W-1:0]  exa_r;
  logic [IDX_W-1:0]  idxa_r;

  logic             vb_r;
  logic [FIN_W-1:0] finb_r;
  logic [IDX_W-1:0] idxb_r;

  logic             found_r;
  logic [FIN_W-1:0] best_r;
  logic [IDX_W-1:0] besti_r;

  logic [IDX_W-1:0]  rd_idx;
  logic [TIME_W-1:0] rd_st, ex_w;
  logic [RUN_W-1:0]  rem;

  assign rd_idx = i_r[IDX_W-1:0];
  assign rd_st  = st_mem[rd_idx];
  assign i_nxt  = i_r + CNT_W'(1);
  assign ex_w   = TIME_W'(exa_r);

  always_comb begin
    rem = '0;
    if (busya_r && ex_w > ela_r) begin
      rem = RUN_W'(ex_w - ela_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (mark.en) begin
      busy_r[mark.idx] <= mark.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (mark.en && mark.busy) begin
      st_mem[mark.idx] <= mark.start;
      ex_mem[mark.idx] <= mark.expected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (start) begin
        active_r <= capable && (count != '0);
      end else if (active_r && i_nxt == cnt_r) begin
        active_r <= 1'b0;
      end
      va_r <= active_r;
      vb_r <= va_r;
      if (start) begin
        found_r <= 1'b0;
      end else if (vb_r && (!found_r || finb_r < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r   <= '0;
      cnt_r <= count;
    end else if (active_r) begin
      i_r <= i_nxt;
    end
    // elapsed time, zero when the clock reads before the start
    ela_r   <= (now >= rd_st) ? (now - rd_st) : '0;
    exa_r   <= ex_mem[rd_idx];
    busya_r <= busy_r[rd_idx];
    idxa_r  <= rd_idx;
    finb_r  <= FIN_W'(run) + FIN_W'(rem);
    idxb_r  <= idxa_r;
    if (vb_r && (!found_r || finb_r < best_r)) begin
      best_r  <= finb_r;
      besti_r <= idxb_r;
    end
  end

  assign done      = !active_r && !va_r && !vb_r;
  assign res.found = found_r;
  assign res.idx   = besti_r;
  assign res.fin   = best_r;

endmodule

@@ src/efas_merge.sv @@
// ----------------------------------------------------------------------------
// efas_merge
// Walks the lane results from the highest type down, one lane a cycle,
// keeping the first strict minimum.
// ----------------------------------------------------------------------------
module efas_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  efas_pkg::lane_res_t lane_res [efas_pkg::TYPE_COUNT],
  output efas_pkg::pick_t     pick,
  output logic                done
);
  import efas_pkg::*;

  logic              active_r;
  logic [TYPE_W-1:0] lc_r;
  logic              found_r;
  logic [TYPE_W-1:0] ptype_r;
  logic [IDX_W-1:0]  idx_r;
  logic [FIN_W-1:0]  fin_r;
  lane_res_t         cur;
  logic              take;

  assign cur  = lane_res[lc_r];
  assign take = active_r && cur.found && (!found_r || cur.fin < fin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
      found_r  <= 1'b0;
    end else if (active_r) begin
      if (lc_r == '0) begin
        active_r <= 1'b0;
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lc_r <= TYPE_W'(TYPE_COUNT - 1);
    end else if (active_r) begin
      lc_r <= lc_r - TYPE_W'(1);
    end
    if (!start && take) begin
      ptype_r <= lc_r;
      idx_r   <= cur.idx;
      fin_r   <= cur.fin;
    end
  end

  assign done       = !active_r;
  assign pick.found = found_r;
  assign pick.ptype = ptype_r;
  assign pick.idx   = idx_r;
  assign pick.fin   = fin_r;

endmodule

@@ src/earliest_finish_accel_select.sv @@
// ----------------------------------------------------------------------------
// earliest_finish_accel_select
// Picks the accelerator instance with the earliest projected finish for a
// job; mark requests keep the per-instance busy table up to date.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tuser cmd, tdata job and times
//  out_    | master    | out_tvalid/tready  | tuser status, tdata choice
//  cfg_    | write     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A mark request updates the busy table and leaves the block ready for the
// next request. For a select, the lanes scan their instances one per cycle
// through a three-stage pipe, then the merge walks the lanes one per cycle.
// Reset clears the busy flags and the registers.
// A result waits in the output register; a new request is taken meanwhile,
// and a select finishing while the output is still full holds there.
// ----------------------------------------------------------------------------
module earliest_finish_accel_select (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd[1:0]
  input  logic [efas_pkg::IN_TUSER_W-1:0]     in_tuser,
  // job_kind[2:0], run_time_type0[34:3], run_time_type1[66:35],
  // run_time_type2[98:67], run_time_type3[130:99], now_time[178:131],
  // target_type[180:179], target_index[182:181], occupant_run_time[214:183]
  input  logic [efas_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0]
  output logic [efas_pkg::OUT_TUSER_W-1:0]    out_tuser,
  // chosen_type[1:0], chosen_index[3:2], projected_finish[36:4]
  output logic [efas_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [efas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efas_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
  import efas_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MERGE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [31:0] cap_r;
  logic [15:0] counts_r;

  logic [2:0]        job_r;
  logic [TIME_W-1:0] now_r;
  logic [RUN_W-1:0]  run_r [RUN_TIME_FIELDS];

  logic                   out_valid_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [1:0]  in_cmd, in_tt, in_ti;
  logic        accept, mark_ok, lanes_start, merge_start, out_load;
  logic [TYPE_COUNT-1:0] lane_done;
  lane_res_t   lane_res [TYPE_COUNT];
  pick_t       pick;
  logic        merge_done;

  assign in_cmd    = in_tuser[1:0];
  assign in_tt     = in_tdata[180:179];
  assign in_ti     = in_tdata[182:181];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign mark_ok   = accept && (in_cmd == CMD_BUSY || in_cmd == CMD_FREE)
                     && (int'(in_tt) < TYPE_COUNT) && (int'(in_ti) < MAX_INSTANCES);
  assign lanes_start = (state_r == S_START);
  assign merge_start = (state_r == S_SCAN) && (&lane_done);
  assign out_load    = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      counts_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAP_MAP: cap_r    <= cfg_wr_data;
        REG_COUNTS:  counts_r <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && in_cmd == CMD_SELECT) state_nxt = S_START;
      S_START:  state_nxt = S_SCAN;
      S_SCAN:   if (&lane_done) state_nxt = S_MERGE;
      S_MERGE:  if (merge_done) state_nxt = S_FINISH;
      S_FINISH: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_SELECT) begin
      job_r    <= in_tdata[2:0];
      run_r[0] <= in_tdata[34:3];
      run_r[1] <= in_tdata[66:35];
      run_r[2] <= in_tdata[98:67];
      run_r[3] <= in_tdata[130:99];
      now_r    <= in_tdata[178:131];
    end
  end

  for (genvar t = 0; t < TYPE_COUNT; t++) begin : g_lane
    mark_t            mk;
    logic [RUN_W-1:0] lane_run;

    assign mk.en       = mark_ok && (int'(in_tt) == t);
    assign mk.busy     = (in_cmd == CMD_BUSY);
    assign mk.idx      = IDX_W'(in_ti);
    assign mk.start    = in_tdata[178:131];
    assign mk.expected = in_tdata[214:183];

    if (t < RUN_TIME_FIELDS) begin : g_run
      assign lane_run = run_r[t];
    end else begin : g_norun
      assign lane_run = '0;
    end

    efas_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .mark    (mk),
      .start   (lanes_start),
      .capable (capable(cap_r, job_r, t)),
      .count   (count_of(counts_r, t)),
      .run     (lane_run),
      .now     (now_r),
      .res     (lane_res[t]),
      .done    (lane_done[t])
    );
  end

  efas_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (merge_start),
    .lane_res (lane_res),
    .pick     (pick),
    .done     (merge_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (job_r == 3'd0) begin
        out_tuser_r <= ST_NO_TASK;
        out_tdata_r <= '0;
      end else if (!pick.found) begin
        out_tuser_r <= ST_NO_CAP;
        out_tdata_r <= '0;
      end else begin
        out_tuser_r <= ST_OK;
        out_tdata_r <= {3'b000, pick.fin, 2'(pick.idx), 2'(pick.ptype)};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the earliest-finish selector. Mark requests keep a local
// copy of the busy table; every select request is predicted and compared
// with the result channel. Both sides stall at random, and the registers
// change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import efas_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int CLK_HALF        = 6;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int TAIL_ITEMS      = 150;
  localparam int PHASE_COUNT     = 8;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [2:0]       job;
    logic [3:0][31:0] run;      // run[t] is the job's run time on type t
    logic [47:0]      stamp;
    logic [1:0]       ttype;
    logic [1:0]       tidx;
    logic [31:0]      occ_run;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  ptype;
    logic [1:0]  pidx;
    logic [32:0] fin;
  } pick_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

  // local copy of the block's registers and instance table
  logic [31:0] cap_reg = '0;
  logic [15:0] counts_reg = '0;
  logic        busy_tbl   [TYPE_COUNT][MAX_INSTANCES];
  logic [47:0] start_tbl  [TYPE_COUNT][MAX_INSTANCES];
  logic [31:0] expect_tbl [TYPE_COUNT][MAX_INSTANCES];

  pick_res_t   expected_picks[$];
  int          error_count = 0;
  int          cycle_count = 0;
  logic        quiet_tail = 1'b0;
  logic [47:0] sim_clock = '0;

  earliest_finish_accel_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("earliest_finish_accel_select regression: fail");
      $finish;
    end
  end

  initial begin
    for (int t = 0; t < TYPE_COUNT; t++) begin
      for (int i = 0; i < MAX_INSTANCES; i++) begin
        busy_tbl[t][i] = 1'b0;
        start_tbl[t][i] = '0;
        expect_tbl[t][i] = '0;
      end
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic pick_res_t pick_earliest(input request_t r);
    pick_res_t   res;
    logic        found;
    logic [32:0] best;
    logic [32:0] fin;
    logic [47:0] elapsed;
    int          n;
    res = '0;
    found = 1'b0;
    best = '0;
    if (r.job == 3'd0) begin
      res.status = ST_NO_TASK;
      return res;
    end
    for (int t = TYPE_COUNT - 1; t >= 0; t--) begin
      if (!cap_reg[int'(r.job) * 4 + t]) continue;
      n = int'(counts_reg[4*t +: 4]);
      if (n > MAX_INSTANCES) n = MAX_INSTANCES;
      for (int i = 0; i < n; i++) begin
        fin = {1'b0, r.run[t]};
        if (busy_tbl[t][i]) begin
          // time before the occupant's start counts as no progress
          elapsed = (r.stamp >= start_tbl[t][i]) ? r.stamp - start_tbl[t][i] : '0;
          if (48'(expect_tbl[t][i]) > elapsed)
            fin = fin + 33'(48'(expect_tbl[t][i]) - elapsed);
        end
        if (!found || fin < best) begin
          found = 1'b1;
          best = fin;
          res.ptype = 2'(t);
          res.pidx = 2'(i);
        end
      end
    end
    if (found) begin
      res.status = ST_OK;
      res.fin = best;
    end else begin
      res = '0;
      res.status = ST_NO_CAP;
    end
    return res;
  endfunction

  function automatic void update_occupancy(input request_t r);
    if (r.cmd == CMD_BUSY) begin
      busy_tbl[r.ttype][r.tidx] = 1'b1;
      start_tbl[r.ttype][r.tidx] = r.stamp;
      expect_tbl[r.ttype][r.tidx] = r.occ_run;
    end else if (r.cmd == CMD_FREE) begin
      busy_tbl[r.ttype][r.tidx] = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    pick_res_t got;
    pick_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.ptype = out_tdata[1:0];
      got.pidx = out_tdata[3:2];
      got.fin = out_tdata[36:4];
      if (expected_picks.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: status %0d type %0d index %0d finish %0d",
                   got.status, got.ptype, got.pidx, got.fin);
      end else begin
        want = expected_picks.pop_front();
        if (got.status !== want.status || got.ptype !== want.ptype ||
            got.pidx !== want.pidx || got.fin !== want.fin) begin
          error_count = error_count + 1;
          if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: status %0d/%0d type %0d/%0d index %0d/%0d %s %0d/%0d",
                     $realtime, want.status, got.status, want.ptype, got.ptype,
                     want.pidx, got.pidx, "finish (exp/act)", want.fin, got.fin);
        end
      end
    end
  end

  // result side backpressure
  initial begin : result_stalls
    int  hold;
    logic stall;
    hold = 0;
    forever begin
      @(negedge clk);
      if (quiet_tail) begin
        out_tready <= 1'b1;
      end else if (hold != 0) begin
        hold = hold - 1;
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        out_tready <= !stall;
        hold = stall ? int'($urandom_range(0, 14)) : int'($urandom_range(0, 30));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  // All driving tasks start and end at a falling edge.

  task automatic send_request(input request_t r);
    in_tuser <= r.cmd;
    in_tdata <= {1'b0, r.occ_run, r.tidx, r.ttype, r.stamp, r.run, r.job};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.cmd == CMD_SELECT) expected_picks.push_back(pick_earliest(r));
    else update_occupancy(r);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_picks(input int settle);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_picks.size() != 0);
    // mark requests give no result and may still be in flight
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    wait_all_picks(SETTLE_CYCLES);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_CAP_MAP) cap_reg = value;
    else counts_reg = value[15:0];
  endtask

  function automatic request_t build_request(input logic [1:0] cmd, input logic [2:0] job,
                                             input logic [3:0][31:0] run,
                                             input logic [47:0] stamp,
                                             input logic [1:0] ttype, input logic [1:0] tidx,
                                             input logic [31:0] occ_run);
    request_t r;
    r.cmd = cmd;
    r.job = job;
    r.run = run;
    r.stamp = stamp;
    r.ttype = ttype;
    r.tidx = tidx;
    r.occ_run = occ_run;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [31:0] random_duration();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return 32'd1000000 * $urandom_range(1, 4);
      4, 5:    return 32'(100 * $urandom_range(1, 3));  // coarse values make ties
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    sim_clock = sim_clock + 48'($urandom_range(0, 3000));
    r.job = 3'($urandom_range(0, 7));
    for (int t = 0; t < TYPE_COUNT; t++) r.run[t] = random_duration();
    r.stamp = ($urandom_range(0, 19) == 0) ? rand48() : sim_clock;
    r.ttype = 2'($urandom_range(0, 3));
    r.tidx = 2'($urandom_range(0, 3));
    r.occ_run = random_duration();
    if (pick < 45) begin
      r.cmd = CMD_SELECT;
      r.job = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    end else if (pick < 75) begin
      r.cmd = CMD_BUSY;
      // start a little behind or ahead of the running time
      if ($urandom_range(0, 9) != 0)
        r.stamp = sim_clock + 48'($urandom_range(0, 1000)) - 48'($urandom_range(0, 4000));
    end else if (pick < 95) begin
      r.cmd = CMD_FREE;
    end else begin
      r.cmd = CMD_UNKNOWN;
    end
    return r;
  endfunction

  task automatic run_random_items(input int n);
    for (int k = 0; k < n; k++) begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 15));
      if (!quiet_tail && $urandom_range(0, 99) == 0) wait_all_picks(0);
      send_request(random_request());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_config();
    // registers come up zero: nothing is capable
    send_request(build_request(CMD_SELECT, 3'd0, '0, '0, 2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd3, {4{32'd50}}, 48'd10, 2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd7, '1, '1, 2'd3, 2'd3, '1));
  endtask

  task automatic test_directed_cases();
    write_register(REG_CAP_MAP, 32'hFFFF_FFFF);
    write_register(REG_COUNTS, 32'h0000_4444);
    send_request(build_request(CMD_SELECT, 3'd0, {4{32'd7}}, 48'd5, 2'd0, 2'd0, '0));
    // all free, equal times: highest type, lowest index wins
    send_request(build_request(CMD_SELECT, 3'd7, '1, '0, 2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd1, '0, 48'd100, 2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd4, {32'd9, 32'd9, 32'd7, 32'd5}, 48'd0,
                               2'd0, 2'd0, '0));
    // type 3 fully busy; at 1200 index 2 starts in the future, at 2000 all have run out
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd1000, 2'd3, 2'd0, 32'd500));
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd1000, 2'd3, 2'd1, 32'd250));
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd1300, 2'd3, 2'd2, 32'd20));
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd1000, 2'd3, 2'd3, 32'd230));
    send_request(build_request(CMD_SELECT, 3'd2, {32'd100, {3{32'hFFFF_FFFF}}}, 48'd1200,
                               2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd2, {32'd100, {3{32'hFFFF_FFFF}}}, 48'd2000,
                               2'd0, 2'd0, '0));
    send_request(build_request(CMD_FREE, 3'd5, '1, '1, 2'd3, 2'd0, '1));
    send_request(build_request(CMD_UNKNOWN, 3'd7, '1, '1, 2'd3, 2'd1, '1));
    send_request(build_request(CMD_SELECT, 3'd2, {32'd100, {3{32'hFFFF_FFFF}}}, 48'd1200,
                               2'd0, 2'd0, '0));
    // largest projected finish: one instance, occupant just started
    send_request(build_request(CMD_BUSY, 3'd0, '0, '1, 2'd2, 2'd0, '1));
    write_register(REG_COUNTS, 32'h0000_0100);
    send_request(build_request(CMD_SELECT, 3'd7, '1, '0, 2'd0, 2'd0, '0));
    send_request(build_request(CMD_SELECT, 3'd6, '1, '1, 2'd0, 2'd0, '0));
    // a count of 15 is clipped to the table depth
    write_register(REG_COUNTS, 32'h0000_00F0);
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd0, 2'd1, 2'd0, 32'd1000));
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd0, 2'd1, 2'd1, 32'd1000));
    send_request(build_request(CMD_BUSY, 3'd0, '0, 48'd0, 2'd1, 2'd2, 32'd1000));
    send_request(build_request(CMD_FREE, 3'd0, '0, 48'd0, 2'd1, 2'd3, '0));
    send_request(build_request(CMD_SELECT, 3'd3, {4{32'd10}}, 48'd0, 2'd0, 2'd0, '0));
    // job kind with no capable type
    write_register(REG_CAP_MAP, 32'hFF0F_FFFF);
    send_request(build_request(CMD_SELECT, 3'd5, {4{32'd10}}, 48'd0, 2'd0, 2'd0, '0));
  endtask

  task automatic test_random_phases();
    logic [31:0] cap;
    logic [15:0] cnt;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      cap = $urandom();
      cnt = {4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)),
             4'($urandom_range(0, 4)), 4'($urandom_range(0, 4))};
      case (ph)
        0: begin cap = 32'hFFFF_FFFF; cnt = 16'h4444; end
        1: cnt = 16'hFFFF;
        2: cap = 32'h0000_0000;
        4: begin cap = 32'hAAAA_5555; cnt = 16'h1234; end
        5: cap = cap | 32'hFFFF_FFF0;
        6: cnt = 16'h0000;
        7: cnt = 16'($urandom());
        default: ;
      endcase
      write_register(REG_CAP_MAP, cap);
      write_register(REG_COUNTS, {16'($urandom()), cnt});
      run_random_items(ITEMS_PER_PHASE);
    end
  endtask

  task automatic test_quiet_tail();
    write_register(REG_CAP_MAP, $urandom() | 32'hFFFF_0000);
    write_register(REG_COUNTS, 32'h0000_4444);
    quiet_tail = 1'b1;
    run_random_items(TAIL_ITEMS);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_directed_cases();
    test_random_phases();
    test_quiet_tail();
    wait_all_picks(SETTLE_CYCLES);
    if (error_count == 0 && expected_picks.size() == 0) begin
      $display("earliest_finish_accel_select regression: pass");
    end else begin
      $display("earliest_finish_accel_select regression: fail");
    end
    $finish;
  end

endmodule
